[rtl/sru_pkg.sv]
`timescale 1ns / 1ps

package sru_pkg;

    localparam int VALUE_W    = 32;
    localparam int INDEX_W    = 32;
    localparam int CFG_DATA_W = 3;

    typedef enum logic [2:0] {
        OP_SUM,
        OP_PRODUCT,
        OP_MIN,
        OP_MAX,
        OP_ARGMIN,
        OP_ARGMAX,
        OP_ALL,
        OP_ANY
    } reduce_op_t;

    typedef logic [0:0] cfg_index_t;

    localparam cfg_index_t REG_REDUCE_OP     = 1'b0;
    localparam cfg_index_t REG_SIGNED_VALUES = 1'b1;

    typedef struct packed {
        reduce_op_t reduce_op;
        logic       signed_values;
    } cfg_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               empty_group;
    } in_word_t;

    typedef struct packed {
        logic [VALUE_W-1:0] result_value;
        logic [INDEX_W-1:0] result_index;
        logic               error;
    } out_word_t;

    // starting value of a group for the configured operation
    function automatic logic [VALUE_W-1:0] identity_of(input cfg_t c);
        logic [VALUE_W-1:0] r;
        r = '0;
        case (c.reduce_op)
            OP_SUM:     r = '0;
            OP_PRODUCT: r = VALUE_W'(1);
            OP_MIN, OP_ARGMIN:
                r = c.signed_values ? {1'b0, {(VALUE_W-1){1'b1}}} : '1;
            OP_MAX, OP_ARGMAX:
                r = c.signed_values ? {1'b1, {(VALUE_W-1){1'b0}}} : '0;
            OP_ALL:     r = VALUE_W'(1);
            OP_ANY:     r = '0;
            default:    r = '0;
        endcase
        return r;
    endfunction

    function automatic logic less_than(input logic [VALUE_W-1:0] a,
                                       input logic [VALUE_W-1:0] b,
                                       input logic               sgn);
        logic r;
        if (sgn)
            r = $signed(a) < $signed(b);
        else
            r = a < b;
        return r;
    endfunction

endpackage

[rtl/sru_if.sv]
`timescale 1ns / 1ps

interface sru_in_if;
    import sru_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               empty_group;

    modport source (output valid, output value, output last, output empty_group,
                    input ready);
    modport sink (input valid, input value, input last, input empty_group,
                  output ready);
endinterface

interface sru_out_if;
    import sru_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] result_value;
    logic [INDEX_W-1:0] result_index;
    logic               error;

    modport source (output valid, output result_value, output result_index,
                    output error, input ready);
    modport sink (input valid, input result_value, input result_index,
                  input error, output ready);
endinterface

[rtl/sru_accum.sv]
`timescale 1ns / 1ps

module sru_accum (
    input  logic             clk,
    input  logic             rst_n,
    input  sru_pkg::cfg_t    cfg,
    input  logic             fire,
    input  sru_pkg::in_word_t word,
    output logic             res_valid,
    output sru_pkg::out_word_t res
);
    import sru_pkg::*;

    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [INDEX_W-1:0] idx_reg, idx_next;
    logic [INDEX_W-1:0] count_reg, count_next;

    logic [VALUE_W-1:0] ident;
    logic [VALUE_W-1:0] base_acc;
    logic [INDEX_W-1:0] base_idx;
    logic               first;
    logic               is_arg;
    logic               empty_err;

    always_comb
    begin
        ident    = identity_of(cfg);
        first    = (count_reg == '0);
        base_acc = first ? ident : acc_reg;
        base_idx = first ? '0 : idx_reg;
        acc_next = base_acc;
        idx_next = base_idx;
        case (cfg.reduce_op)
            OP_SUM:     acc_next = base_acc + word.value;
            OP_PRODUCT: acc_next = VALUE_W'(base_acc * word.value);
            OP_MIN:
                if (less_than(word.value, base_acc, cfg.signed_values))
                    acc_next = word.value;
            OP_MAX:
                if (less_than(base_acc, word.value, cfg.signed_values))
                    acc_next = word.value;
            OP_ARGMIN:
                // ties move to the later position
                if (!less_than(base_acc, word.value, cfg.signed_values))
                begin
                    acc_next = word.value;
                    idx_next = count_reg;
                end
            OP_ARGMAX:
                if (!less_than(word.value, base_acc, cfg.signed_values))
                begin
                    acc_next = word.value;
                    idx_next = count_reg;
                end
            OP_ALL:
                acc_next = VALUE_W'((base_acc != '0) && (word.value != '0));
            OP_ANY:
                acc_next = VALUE_W'((base_acc != '0) || (word.value != '0));
            default:    acc_next = base_acc;
        endcase

        // group closes on last or empty, so count returns to zero
        if (word.empty_group || word.last)
            count_next = '0;
        else
            count_next = count_reg + INDEX_W'(1);
    end

    always_comb
    begin
        is_arg    = (cfg.reduce_op == OP_ARGMIN) || (cfg.reduce_op == OP_ARGMAX);
        empty_err = (cfg.reduce_op == OP_MIN) || (cfg.reduce_op == OP_MAX);
        res_valid = word.empty_group || word.last;
        if (word.empty_group)
        begin
            res.result_value = empty_err ? '0 : ident;
            res.result_index = '0;
            res.error        = empty_err;
        end
        else
        begin
            res.result_value = acc_next;
            res.result_index = is_arg ? idx_next : '0;
            res.error        = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (fire)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            acc_reg <= acc_next;
            idx_reg <= idx_next;
        end
    end

endmodule

[rtl/sru_out_reg.sv]
`timescale 1ns / 1ps

module sru_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  sru_pkg::out_word_t data,
    output logic               can_take,
    sru_out_if.source          out_stream
);
    import sru_pkg::*;

    logic      valid_reg;
    out_word_t data_reg;

    assign can_take = !valid_reg || out_stream.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (out_stream.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data;
    end

    assign out_stream.valid        = valid_reg;
    assign out_stream.result_value = data_reg.result_value;
    assign out_stream.result_index = data_reg.result_index;
    assign out_stream.error        = data_reg.error;

endmodule

[rtl/stream_reduce_unit.sv]
`timescale 1ns / 1ps

// channel      dir   payload                                  handshake
// in_stream    in    value[31:0], last, empty_group           valid/ready
// out_stream   out   result_value[31:0], result_index[31:0],  valid/ready
//                    error
// cfg          in    cfg_we, cfg_index[0:0], cfg_data[2:0]    write on cfg_we
//
// one word per cycle sustained while out_stream does not stall; a result
// shows on out_stream once its closing word has passed the input register,
// then the fold logic into the result register
// the fold (add, 32x32 low-half multiply, compare or logical and/or) sits
// between the input register and the accumulator / result register
// rst_n clears the valid flags, element count and config (sum, signed)
// a stall on out_stream holds the input register; in_stream takes at most one
// word, into an empty input register, while the result register waits

module stream_reduce_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    sru_in_if.sink                           in_stream,
    sru_out_if.source                        out_stream,
    input  logic                             cfg_we,
    input  sru_pkg::cfg_index_t              cfg_index,
    input  logic [sru_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sru_pkg::*;

    // configuration registers
    cfg_t      cfg_reg;

    // input register
    logic      in_valid_reg;
    in_word_t  in_word_reg;

    logic      advance;     // result register can take a word
    logic      fire;        // input register word folded this cycle
    logic      accept;      // word taken from in_stream
    logic      res_valid;
    out_word_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reduce_op     <= OP_SUM;
            cfg_reg.signed_values <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_REDUCE_OP:     cfg_reg.reduce_op     <= reduce_op_t'(cfg_data[2:0]);
                REG_SIGNED_VALUES: cfg_reg.signed_values <= cfg_data[0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // the input register drains whenever the result side moves
    assign fire            = in_valid_reg && advance;
    assign in_stream.ready = !in_valid_reg || advance;
    assign accept          = in_stream.valid && in_stream.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (accept)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_word_reg.value       <= in_stream.value;
            in_word_reg.last        <= in_stream.last;
            in_word_reg.empty_group <= in_stream.empty_group;
        end
    end

    // accumulator, best index and element count with the fold logic
    sru_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .fire      (fire),
        .word      (in_word_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register; only the closing word of a group loads it
    sru_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire && res_valid),
        .data       (res),
        .can_take   (advance),
        .out_stream (out_stream)
    );

endmodule

[rtl/sru_checker.sv]
`timescale 1ns / 1ps

module sru_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_value,
    input logic [31:0] out_index,
    input logic        out_error
);

    // a held result keeps its word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value)
            && $stable(out_index) && $stable(out_error))
        else $error("result word changed while stalled");

    // an empty min or max gives zero value and zero index
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_error |-> out_value == 32'd0 && out_index == 32'd0)
        else $error("error result carries nonzero payload");

    // input side only backs up behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // a fresh result follows a word taken from the input stream
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a matching input word");

endmodule

bind stream_reduce_unit sru_checker u_sru_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_stream.valid),
    .in_ready  (in_stream.ready),
    .out_valid (out_stream.valid),
    .out_ready (out_stream.ready),
    .out_value (out_stream.result_value),
    .out_index (out_stream.result_index),
    .out_error (out_stream.error)
);
